FILE: rtl/clns_pkg.sv
// Shared types, codes and constant tables for the character LCD nibble sequencer.
package clns_pkg;

    localparam int CMD_W  = 3;
    localparam int WAIT_W = 16;
    localparam int STEP_W = 4;
    localparam int IDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RAW   = 3'd4;

    localparam logic [IDX_W-1:0] REG_CHAR_WAIT     = 2'd0;
    localparam logic [IDX_W-1:0] REG_COMMAND_WAIT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CLEAR_WAIT    = 2'd2;
    localparam logic [IDX_W-1:0] REG_POWER_UP_WAIT = 2'd3;

    localparam logic [WAIT_W-1:0] RST_CHAR_WAIT     = 16'd46;
    localparam logic [WAIT_W-1:0] RST_COMMAND_WAIT  = 16'd40;
    localparam logic [WAIT_W-1:0] RST_CLEAR_WAIT    = 16'd1000;
    localparam logic [WAIT_W-1:0] RST_POWER_UP_WAIT = 16'd15000;

    localparam logic [WAIT_W-1:0] WAKE_WAIT_LONG  = 16'd4100;
    localparam logic [WAIT_W-1:0] WAKE_WAIT_SHORT = 16'd100;

    localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
    localparam logic [7:0] BYTE_CLEAR    = 8'h01;
    localparam logic [7:0] BYTE_HOME     = 8'h80;
    localparam logic [7:0] ROW0_BASE     = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'hC0;
    localparam logic [2:0] INIT_CLEAR_IX = 3'd3;

    localparam logic [STEP_W-1:0] LAST_STEP_BYTE  = 4'd1;
    localparam logic [STEP_W-1:0] LAST_STEP_CLEAR = 4'd3;
    localparam logic [STEP_W-1:0] LAST_STEP_INIT  = 4'd14;
    localparam logic [STEP_W-1:0] STEP_WAKE_LONG  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WAKE_SHORT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_INIT_BYTES = 4'd3;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_CLEAR,
        KIND_INIT
    } t_kind;

    typedef struct packed {
        logic [WAIT_W-1:0] char_wait;
        logic [WAIT_W-1:0] command_wait;
        logic [WAIT_W-1:0] clear_wait;
        logic [WAIT_W-1:0] power_up_wait;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic              rs;
        logic [WAIT_W-1:0] wait_us;
    } t_job;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              rs_level;
        logic              strobe;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_xfer;

    function automatic logic [7:0] init_byte(input logic [2:0] ix);
        logic [7:0] b;
        case (ix)
            3'd0:    b = 8'h32;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/clns_front.sv
// Command decoder that turns one accepted command into a queued job descriptor.
module clns_front (
    input  logic [clns_pkg::CMD_W-1:0]  i_command,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_register_select,
    input  logic [clns_pkg::WAIT_W-1:0] i_raw_wait_us,
    input  logic [1:0]                  i_row,
    input  logic [5:0]                  i_column,
    input  clns_pkg::t_cfg              i_cfg,
    output clns_pkg::t_job              o_job,
    output logic                        o_emits
);
    import clns_pkg::*;

    logic [7:0] row_base;

    assign row_base = i_row[0] ? ROW1_BASE : ROW0_BASE;

    always_comb begin
        o_job.kind    = KIND_BYTE;
        o_job.data    = i_data_byte;
        o_job.rs      = 1'b0;
        o_job.wait_us = i_cfg.command_wait;
        o_emits       = 1'b0;
        case (i_command)
            CMD_INIT: begin
                o_job.kind = KIND_INIT;
                o_emits    = 1'b1;
            end
            CMD_CHAR: begin
                o_job.rs      = 1'b1;
                o_job.wait_us = i_cfg.char_wait;
                o_emits       = 1'b1;
            end
            CMD_CLEAR: begin
                o_job.kind = KIND_CLEAR;
                o_emits    = 1'b1;
            end
            CMD_MOVE: begin
                o_job.data = row_base + {2'b00, i_column};
                o_emits    = ~i_row[1];
            end
            CMD_RAW: begin
                o_job.rs      = i_register_select;
                o_job.wait_us = i_raw_wait_us;
                o_emits       = 1'b1;
            end
            default: begin
                o_emits = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/clns_queue.sv
// Small job queue that decouples the command decoder from the transfer sequencer.
module clns_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clns_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output clns_pkg::t_job o_job,
    input  logic           i_pop
);
    import clns_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/clns_back.sv
// Transfer sequencer that steps through a queued job and drives the output register.
module clns_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  clns_pkg::t_cfg              i_cfg,
    input  logic                        i_job_valid,
    input  clns_pkg::t_job              i_job,
    output logic                        o_job_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output clns_pkg::t_xfer             o_xfer
);
    import clns_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    t_xfer             r_xfer;
    t_xfer             cur;
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] init_k;
    logic [7:0]        cur_byte;
    logic              load;

    assign init_k = r_step - STEP_INIT_BYTES;
    assign load   = i_job_valid && (!r_out_valid || i_ready);

    always_comb begin
        cur_byte        = i_job.data;
        cur.nibble      = 4'h0;
        cur.rs_level    = 1'b0;
        cur.strobe      = 1'b1;
        cur.wait_us     = i_cfg.command_wait;
        cur.last        = 1'b0;
        last_step       = LAST_STEP_BYTE;
        case (i_job.kind)
            KIND_BYTE: begin
                cur_byte     = i_job.data;
                cur.rs_level = i_job.rs;
                cur.wait_us  = i_job.wait_us;
                last_step    = LAST_STEP_BYTE;
            end
            KIND_CLEAR: begin
                cur_byte    = r_step[1] ? BYTE_HOME : BYTE_CLEAR;
                cur.wait_us = r_step[1] ? i_cfg.command_wait : i_cfg.clear_wait;
                last_step   = LAST_STEP_CLEAR;
            end
            KIND_INIT: begin
                cur_byte  = init_byte(init_k[3:1]);
                last_step = LAST_STEP_INIT;
                if (init_k[3:1] == INIT_CLEAR_IX) begin
                    cur.wait_us = i_cfg.clear_wait;
                end
            end
            default: begin
                last_step = LAST_STEP_BYTE;
            end
        endcase

        if (i_job.kind == KIND_INIT) begin
            cur.nibble = init_k[0] ? cur_byte[3:0] : cur_byte[7:4];
        end else begin
            cur.nibble = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
        end

        if (i_job.kind == KIND_INIT) begin
            if (r_step == '0) begin
                cur.nibble  = 4'h0;
                cur.strobe  = 1'b0;
                cur.wait_us = i_cfg.power_up_wait;
            end else if (r_step == STEP_WAKE_LONG) begin
                cur.nibble  = WAKE_NIBBLE;
                cur.wait_us = WAKE_WAIT_LONG;
            end else if (r_step == STEP_WAKE_SHORT) begin
                cur.nibble  = WAKE_NIBBLE;
                cur.wait_us = WAKE_WAIT_SHORT;
            end
        end

        cur.last = (r_step == last_step);
    end

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_step      = cur.last ? '0 : r_step + 1'b1;
        end
    end

    assign o_job_pop = load && cur.last;
    assign o_valid   = r_out_valid;
    assign o_xfer    = r_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_xfer <= cur;
        end
    end

endmodule

FILE: rtl/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD nibble sequencer: config registers, decoder, queue, sequencer.
//
// The input channel (i_valid/o_ready) takes one command beat: init, character write,
// clear, cursor move or raw byte. The output channel (o_valid/i_ready) gives one
// nibble transfer per beat, high nibble first, with o_last on the final transfer
// of each command. Commands that produce nothing (row 2 or 3, unknown codes) are
// accepted and dropped.
// A command's first transfer is written into the job queue and then loaded into the output
// register before it appears. The sequencer emits one transfer per cycle while i_ready is
// high and a job is queued; a character or raw write gives 2 transfers, a clear 4 and an
// init 15, each held in turn by the single output register.
// Commands are accepted every cycle while the job queue (QUEUE_DEPTH entries) has
// room, also while a transfer waits on a stalled receiver.
// When i_ready is low the current transfer holds and the sequencer pauses; the
// queue then fills and o_ready falls.
// Reset empties the queue and output register and loads the default wait values.
// The config port writes a wait register at any edge with i_cfg_we high, outside reset.
module char_lcd_nibble_sequencer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [clns_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [clns_pkg::WAIT_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [clns_pkg::CMD_W-1:0]  i_command,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_register_select,
    input  logic [clns_pkg::WAIT_W-1:0] i_raw_wait_us,
    input  logic [1:0]                  i_row,
    input  logic [5:0]                  i_column,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3:0]                  o_nibble,
    output logic                        o_rs_level,
    output logic                        o_strobe_res,
    output logic [clns_pkg::WAIT_W-1:0] o_wait_us,
    output logic                        o_last
);
    import clns_pkg::*;

    t_cfg  r_cfg;
    t_job  front_job;
    t_job  head_job;
    t_xfer xfer;
    logic  front_emits;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_wait     <= RST_CHAR_WAIT;
            r_cfg.command_wait  <= RST_COMMAND_WAIT;
            r_cfg.clear_wait    <= RST_CLEAR_WAIT;
            r_cfg.power_up_wait <= RST_POWER_UP_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHAR_WAIT:     r_cfg.char_wait     <= i_cfg_data;
                REG_COMMAND_WAIT:  r_cfg.command_wait  <= i_cfg_data;
                REG_CLEAR_WAIT:    r_cfg.clear_wait    <= i_cfg_data;
                REG_POWER_UP_WAIT: r_cfg.power_up_wait <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_ready = !q_full;

    clns_front u_front (
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_register_select (i_register_select),
        .i_raw_wait_us     (i_raw_wait_us),
        .i_row             (i_row),
        .i_column          (i_column),
        .i_cfg             (r_cfg),
        .o_job             (front_job),
        .o_emits           (front_emits)
    );

    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && o_ready && front_emits),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    clns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_job_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_xfer      (xfer)
    );

    assign o_nibble     = xfer.nibble;
    assign o_rs_level   = xfer.rs_level;
    assign o_strobe_res = xfer.strobe;
    assign o_wait_us    = xfer.wait_us;
    assign o_last       = xfer.last;

endmodule

FILE: rtl/clns_checker.sv
// Port-level checks on the nibble sequencer, bound to the top level.
module clns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_nibble,
    input logic        o_rs_level,
    input logic        o_strobe_res,
    input logic [15:0] o_wait_us,
    input logic        o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid seen right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_nibble) && $stable(o_wait_us)
            && $stable(o_last))
        else $error("stalled output beat changed");

    a_wait_only_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_strobe_res |-> o_nibble == 4'h0 && !o_rs_level)
        else $error("wait-only beat carries data");

    a_wait_only_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_strobe_res |-> !o_last)
        else $error("wait-only beat marked last");

endmodule

bind char_lcd_nibble_sequencer_top clns_checker u_clns_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for the character LCD nibble sequencer: scoreboard, stimulus, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clns_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [7:0]        data_byte;
        logic              rs;
        logic [WAIT_W-1:0] raw_wait;
        logic [1:0]        row;
        logic [5:0]        column;
    } t_lcd_cmd;

    class lcd_xfer_scoreboard;
        t_xfer             expected_q[$];
        logic [WAIT_W-1:0] char_wait;
        logic [WAIT_W-1:0] command_wait;
        logic [WAIT_W-1:0] clear_wait;
        logic [WAIT_W-1:0] power_up_wait;
        int                errors;

        function new();
            char_wait     = 16'd46;
            command_wait  = 16'd40;
            clear_wait    = 16'd1000;
            power_up_wait = 16'd15000;
            errors        = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [WAIT_W-1:0] value);
            case (idx)
                REG_CHAR_WAIT:     char_wait     = value;
                REG_COMMAND_WAIT:  command_wait  = value;
                REG_CLEAR_WAIT:    clear_wait    = value;
                REG_POWER_UP_WAIT: power_up_wait = value;
                default: ;
            endcase
        endfunction

        function void push_xfer(logic [3:0] nib, logic rs, logic strobe,
                                logic [WAIT_W-1:0] wait_val);
            t_xfer x;
            x.nibble   = nib;
            x.rs_level = rs;
            x.strobe   = strobe;
            x.wait_us  = wait_val;
            x.last     = 1'b0;
            expected_q.push_back(x);
        endfunction

        function void push_byte(logic [7:0] b, logic rs, logic [WAIT_W-1:0] wait_val);
            push_xfer(b[7:4], rs, 1'b1, wait_val);
            push_xfer(b[3:0], rs, 1'b1, wait_val);
        endfunction

        // Returns the number of transfers the command produces.
        function int note_command(t_lcd_cmd c);
            int before_n;
            before_n = expected_q.size();
            case (c.command)
                CMD_INIT: begin
                    push_xfer(4'h0, 1'b0, 1'b0, power_up_wait);
                    push_xfer(4'h3, 1'b0, 1'b1, 16'd4100);
                    push_xfer(4'h3, 1'b0, 1'b1, 16'd100);
                    push_byte(8'h32, 1'b0, command_wait);
                    push_byte(8'h28, 1'b0, command_wait);
                    push_byte(8'h08, 1'b0, command_wait);
                    push_byte(8'h01, 1'b0, clear_wait);
                    push_byte(8'h06, 1'b0, command_wait);
                    push_byte(8'h0C, 1'b0, command_wait);
                end
                CMD_CHAR:  push_byte(c.data_byte, 1'b1, char_wait);
                CMD_CLEAR: begin
                    push_byte(8'h01, 1'b0, clear_wait);
                    push_byte(8'h80, 1'b0, command_wait);
                end
                CMD_MOVE: begin
                    if (c.row == 2'd0) begin
                        push_byte(8'h80 + {2'b00, c.column}, 1'b0, command_wait);
                    end else if (c.row == 2'd1) begin
                        push_byte(8'hC0 + {2'b00, c.column}, 1'b0, command_wait);
                    end
                end
                CMD_RAW:   push_byte(c.data_byte, c.rs, c.raw_wait);
                default: ;
            endcase
            if (expected_q.size() > before_n) begin
                expected_q[expected_q.size()-1].last = 1'b1;
            end
            return expected_q.size() - before_n;
        endfunction

        function void check_transfer(t_xfer act);
            t_xfer exp_x;
            if (expected_q.size() == 0) begin
                $error("unexpected transfer: nibble %0h wait %0d", act.nibble, act.wait_us);
                errors++;
                return;
            end
            exp_x = expected_q.pop_front();
            if (act.nibble !== exp_x.nibble) begin
                $error("nibble: expected %0h, got %0h", exp_x.nibble, act.nibble);
                errors++;
            end
            if (act.rs_level !== exp_x.rs_level) begin
                $error("rs_level: expected %0d, got %0d", exp_x.rs_level, act.rs_level);
                errors++;
            end
            if (act.strobe !== exp_x.strobe) begin
                $error("strobe_res: expected %0d, got %0d", exp_x.strobe, act.strobe);
                errors++;
            end
            if (act.wait_us !== exp_x.wait_us) begin
                $error("wait_us: expected %0d, got %0d", exp_x.wait_us, act.wait_us);
                errors++;
            end
            if (act.last !== exp_x.last) begin
                $error("last: expected %0d, got %0d", exp_x.last, act.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [WAIT_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [CMD_W-1:0]  i_command;
    logic [7:0]        i_data_byte;
    logic              i_register_select;
    logic [WAIT_W-1:0] i_raw_wait_us;
    logic [1:0]        i_row;
    logic [5:0]        i_column;
    logic              o_valid;
    logic              i_ready;
    logic [3:0]        o_nibble;
    logic              o_rs_level;
    logic              o_strobe_res;
    logic [WAIT_W-1:0] o_wait_us;
    logic              o_last;

    lcd_xfer_scoreboard sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    char_lcd_nibble_sequencer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_register_select (i_register_select),
        .i_raw_wait_us     (i_raw_wait_us),
        .i_row             (i_row),
        .i_column          (i_column),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_nibble          (o_nibble),
        .o_rs_level        (o_rs_level),
        .o_strobe_res      (o_strobe_res),
        .o_wait_us         (o_wait_us),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_xfer act;
        if (i_rst_n && o_valid && i_ready) begin
            act.nibble   = o_nibble;
            act.rs_level = o_rs_level;
            act.strobe   = o_strobe_res;
            act.wait_us  = o_wait_us;
            act.last     = o_last;
            sb.check_transfer(act);
        end
    end

    function automatic t_lcd_cmd mk_cmd(logic [CMD_W-1:0] command, logic [7:0] data_byte,
                                        logic rs, logic [WAIT_W-1:0] raw_wait,
                                        logic [1:0] row, logic [5:0] column);
        t_lcd_cmd c;
        c.command   = command;
        c.data_byte = data_byte;
        c.rs        = rs;
        c.raw_wait  = raw_wait;
        c.row       = row;
        c.column    = column;
        return c;
    endfunction

    function automatic t_lcd_cmd rand_cmd();
        t_lcd_cmd c;
        int       pick;
        pick        = $urandom_range(99);
        c.data_byte = 8'($urandom_range(255));
        c.rs        = 1'($urandom_range(1));
        c.raw_wait  = WAIT_W'($urandom_range(65535));
        c.row       = ($urandom_range(9) < 8) ? 2'($urandom_range(1))
                                               : 2'($urandom_range(3, 2));
        c.column    = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                : 6'($urandom_range(39));
        if (pick < 6)        c.command = CMD_INIT;
        else if (pick < 36)  c.command = CMD_CHAR;
        else if (pick < 46)  c.command = CMD_CLEAR;
        else if (pick < 66)  c.command = CMD_MOVE;
        else if (pick < 92)  c.command = CMD_RAW;
        else                 c.command = CMD_W'($urandom_range(7, 5));
        if ($urandom_range(9) == 0) begin
            c.raw_wait = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return c;
    endfunction

    task automatic send_command(input t_lcd_cmd c, output int produced);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid           = 1'b1;
        i_command         = c.command;
        i_data_byte       = c.data_byte;
        i_register_select = c.rs;
        i_raw_wait_us     = c.raw_wait;
        i_row             = c.row;
        i_column          = c.column;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        produced = sb.note_command(c);
    endtask

    task automatic send_random(input int productive);
        int count;
        int produced;
        count = 0;
        while (count < productive) begin
            send_command(rand_cmd(), produced);
            if (produced > 0) count++;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_waits(input logic [WAIT_W-1:0] char_v, input logic [WAIT_W-1:0] cmd_v,
                              input logic [WAIT_W-1:0] clear_v,
                              input logic [WAIT_W-1:0] power_v);
        logic [WAIT_W-1:0] vals[4];
        vals[0] = char_v;
        vals[1] = cmd_v;
        vals[2] = clear_v;
        vals[3] = power_v;
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we    = 1'b1;
            i_cfg_index = i[IDX_W-1:0];
            i_cfg_data  = vals[i];
            sb.set_reg(i[IDX_W-1:0], vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("char_lcd_nibble_sequencer_top: mismatch");
        $finish;
    end

    initial begin
        t_lcd_cmd directed_q[$];
        int       produced;
        sb                = new();
        send_idle_pct     = 30;
        recv_idle_pct     = 64;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_ready           = 1'b0;
        i_command         = '0;
        i_data_byte       = '0;
        i_register_select = 1'b0;
        i_raw_wait_us     = '0;
        i_row             = '0;
        i_column          = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_q.push_back(mk_cmd(CMD_INIT,  8'h00, 1'b0, 16'h0000, 2'd0, 6'd0));
        directed_q.push_back(mk_cmd(CMD_CHAR,  8'h00, 1'b0, 16'h0000, 2'd0, 6'd0));
        directed_q.push_back(mk_cmd(CMD_CHAR,  8'hFF, 1'b1, 16'hFFFF, 2'd3, 6'd63));
        directed_q.push_back(mk_cmd(CMD_CHAR,  8'hA5, 1'b0, 16'h1234, 2'd1, 6'd7));
        directed_q.push_back(mk_cmd(CMD_CLEAR, 8'hFF, 1'b1, 16'hFFFF, 2'd3, 6'd63));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'h00, 1'b0, 16'h0000, 2'd0, 6'd0));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'hFF, 1'b1, 16'hFFFF, 2'd1, 6'd39));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'h00, 1'b0, 16'h0000, 2'd0, 6'd63));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'h00, 1'b0, 16'h0000, 2'd1, 6'd63));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'h00, 1'b0, 16'h0000, 2'd2, 6'd5));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'h00, 1'b0, 16'h0000, 2'd3, 6'd0));
        directed_q.push_back(mk_cmd(CMD_MOVE,  8'h3C, 1'b1, 16'hFFFF, 2'd1, 6'd0));
        directed_q.push_back(mk_cmd(CMD_RAW,   8'h00, 1'b0, 16'h0000, 2'd0, 6'd0));
        directed_q.push_back(mk_cmd(CMD_RAW,   8'hFF, 1'b1, 16'hFFFF, 2'd3, 6'd63));
        directed_q.push_back(mk_cmd(CMD_RAW,   8'h5A, 1'b1, 16'h8001, 2'd2, 6'd21));
        directed_q.push_back(mk_cmd(CMD_RAW,   8'hC3, 1'b0, 16'h7FFE, 2'd1, 6'd42));
        directed_q.push_back(mk_cmd(3'd5,      8'hFF, 1'b1, 16'hFFFF, 2'd0, 6'd1));
        directed_q.push_back(mk_cmd(3'd6,      8'h12, 1'b0, 16'h0040, 2'd1, 6'd2));
        directed_q.push_back(mk_cmd(3'd7,      8'h00, 1'b1, 16'h0000, 2'd3, 6'd3));
        directed_q.push_back(mk_cmd(CMD_CHAR,  8'h41, 1'b0, 16'h0000, 2'd0, 6'd0));
        directed_q.push_back(mk_cmd(CMD_INIT,  8'hFF, 1'b1, 16'hFFFF, 2'd3, 6'd63));
        foreach (directed_q[i]) send_command(directed_q[i], produced);

        send_random(30);
        drain();
        load_waits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_random(25);

        drain();
        send_idle_pct = 64;
        recv_idle_pct = 30;
        load_waits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(45);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_waits(WAIT_W'($urandom_range(65535)), WAIT_W'($urandom_range(65535)),
                   WAIT_W'($urandom_range(65535)), WAIT_W'($urandom_range(65535)));
        send_random(35);
        drain();
        load_waits(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE);
        send_random(35);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("char_lcd_nibble_sequencer_top: match");
        end else begin
            $display("char_lcd_nibble_sequencer_top: mismatch");
        end
        $finish;
    end

endmodule
